[sv/rau_pkg.sv]
// Shared types, codes and constants for the rational arithmetic unit.
package rau_pkg;

  localparam int unsigned MagWidth = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_DIV_ZERO = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  // Datapath micro-commands issued by the controller.
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,
    CMD_GCD1_INIT,
    CMD_GCD2_INIT,
    CMD_GCDR_INIT,
    CMD_GCD_STEP,
    CMD_DIV1_INIT,
    CMD_DIV2_INIT,
    CMD_DIVR_INIT,
    CMD_DIV_STEP,
    CMD_MUL_A,
    CMD_MUL_B,
    CMD_MUL_C,
    CMD_COMBINE,
    CMD_FINISH
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_GCD1,
    S_DIV1,
    S_GCD2,
    S_DIV2,
    S_MULA,
    S_MULB,
    S_MULC,
    S_COMBINE,
    S_GCDR,
    S_DIVR,
    S_FINISH,
    S_OUT
  } state_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic zero_den;
    logic div_zero;
    logic res_zero;
  } dp_status_t;

endpackage

[sv/rau_ctrl.sv]
// Controller state machine sequencing the rational arithmetic datapath.
module rau_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rau_pkg::dp_status_t dp_st,
  output rau_pkg::cmd_t       cmd
);
  import rau_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_IDLE;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = CMD_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (dp_st.zero_den) begin
          cmd = CMD_FINISH;
          state_nxt = S_OUT;
        end else begin
          cmd = CMD_GCD1_INIT;
          state_nxt = S_GCD1;
        end
      end
      S_GCD1: begin
        if (dp_st.gcd_done) begin
          cmd = CMD_DIV1_INIT;
          state_nxt = S_DIV1;
        end else begin
          cmd = CMD_GCD_STEP;
        end
      end
      S_DIV1: begin
        if (dp_st.div_done) begin
          cmd = CMD_GCD2_INIT;
          state_nxt = S_GCD2;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_GCD2: begin
        if (dp_st.gcd_done) begin
          cmd = CMD_DIV2_INIT;
          state_nxt = S_DIV2;
        end else begin
          cmd = CMD_GCD_STEP;
        end
      end
      S_DIV2: begin
        if (dp_st.div_done) begin
          if (dp_st.div_zero) begin
            cmd = CMD_FINISH;
            state_nxt = S_OUT;
          end else begin
            cmd = CMD_MUL_A;
            state_nxt = S_MULA;
          end
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_MULA: begin
        cmd = CMD_MUL_B;
        state_nxt = S_MULB;
      end
      S_MULB: begin
        cmd = CMD_MUL_C;
        state_nxt = S_MULC;
      end
      S_MULC: begin
        cmd = CMD_COMBINE;
        state_nxt = S_COMBINE;
      end
      S_COMBINE: begin
        if (dp_st.res_zero) begin
          cmd = CMD_FINISH;
          state_nxt = S_OUT;
        end else begin
          cmd = CMD_GCDR_INIT;
          state_nxt = S_GCDR;
        end
      end
      S_GCDR: begin
        if (dp_st.gcd_done) begin
          cmd = CMD_DIVR_INIT;
          state_nxt = S_DIVR;
        end else begin
          cmd = CMD_GCD_STEP;
        end
      end
      S_DIVR: begin
        if (dp_st.div_done) begin
          cmd = CMD_FINISH;
          state_nxt = S_OUT;
        end else begin
          cmd = CMD_DIV_STEP;
        end
      end
      S_FINISH: begin
        cmd = CMD_FINISH;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("second request taken");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
`endif

endmodule

[sv/rau_datapath.sv]
// Datapath: operand decode, binary gcd, restoring division and cross products.
module rau_datapath #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic                 clk,
  input  rau_pkg::cmd_t        cmd,
  input  logic [1:0]           op,
  input  logic [31:0]          left_num,
  input  logic [31:0]          left_den,
  input  logic [31:0]          right_num,
  input  logic [31:0]          right_den,
  output rau_pkg::dp_status_t  dp_st,
  output logic [63:0]          result_num,
  output logic [62:0]          result_den,
  output logic [1:0]           status
);
  import rau_pkg::*;

  localparam int unsigned W = OPERAND_WIDTH;

  // Operand registers: signs and magnitudes.
  logic [1:0]  opc_r;
  logic        n1s_r, d1s_r, n2s_r, d2s_r;
  logic [W:0]  n1m_r, d1m_r, n2m_r, d2m_r;
  // Products and result.
  logic [63:0] p1_r, p2_r, rd_r;
  logic [64:0] rnm_r;
  logic        rns_r;
  // GCD unit.
  logic [64:0] ga_r, gb_r;
  logic [6:0]  gk_r;
  logic [64:0] g_r;
  // Divider unit: quotient of two values by g_r.
  logic [64:0] dq_r, drem_r, dq2_r, drem2_r, dn1_r, dn2_r;
  logic [6:0]  dcnt_r;
  logic [1:0]  dsel_r;
  logic [63:0] out_num_r;
  logic [62:0] out_den_r;
  logic [1:0]  out_st_r;

  function automatic logic [W:0] mag_of(input logic [31:0] raw);
    logic [W-1:0] v;
    logic [W-1:0] n;
    v = raw[W-1:0];
    n = ~v + 1'b1;
    mag_of = v[W-1] ? {n == '0, n} : {1'b0, v};
  endfunction

  logic [64:0] gsub;
  logic [64:0] dtry1, dtry2;
  logic        both_even;
  logic [31:0] mulx, muly;
  logic [63:0] mprod;

  assign both_even = !ga_r[0] && !gb_r[0];
  assign gsub  = (ga_r > gb_r) ? ga_r - gb_r : gb_r - ga_r;
  assign dtry1 = {drem_r[63:0], dn1_r[64]};
  assign dtry2 = {drem2_r[63:0], dn2_r[64]};

  always_comb begin
    mulx = '0;
    muly = '0;
    unique case (cmd)
      CMD_MUL_A: begin
        mulx = 32'(n1m_r);
        muly = (opc_r == OP_DIV || opc_r == OP_MUL) ?
               ((opc_r == OP_MUL) ? 32'(n2m_r) : 32'(d2m_r)) : 32'(d2m_r);
      end
      CMD_MUL_B: begin
        mulx = 32'(d1m_r);
        muly = (opc_r == OP_DIV) ? 32'(n2m_r) : 32'(d2m_r);
      end
      CMD_MUL_C: begin
        mulx = 32'(n2m_r);
        muly = 32'(d1m_r);
      end
      default: ;
    endcase
  end
  assign mprod = {32'd0, mulx} * {32'd0, muly};

  assign dp_st.gcd_done = (gb_r == '0);
  assign dp_st.div_done = (dcnt_r == '0);
  assign dp_st.zero_den = (d1m_r == '0) || (d2m_r == '0);
  assign dp_st.div_zero = (opc_r == OP_DIV) && (n2m_r == '0);
  assign dp_st.res_zero = (rnm_r == '0);

  always_ff @(posedge clk) begin
    unique case (cmd) inside
      CMD_LOAD: begin
        opc_r <= op;
        n1s_r <= left_num[W-1];  n1m_r <= mag_of(left_num);
        d1s_r <= left_den[W-1];  d1m_r <= mag_of(left_den);
        n2s_r <= right_num[W-1]; n2m_r <= mag_of(right_num);
        d2s_r <= right_den[W-1]; d2m_r <= mag_of(right_den);
      end
      CMD_GCD1_INIT: begin
        gk_r <= '0;
        if (n1m_r == '0) begin
          gb_r <= '0; ga_r <= 65'(d1m_r); // divides denominator to 1
        end else begin
          ga_r <= 65'(n1m_r); gb_r <= 65'(d1m_r);
        end
      end
      CMD_GCD2_INIT: begin
        gk_r <= '0;
        if (n2m_r == '0) begin
          gb_r <= '0; ga_r <= 65'(d2m_r);
        end else begin
          ga_r <= 65'(n2m_r); gb_r <= 65'(d2m_r);
        end
      end
      CMD_GCDR_INIT: begin
        ga_r <= rnm_r; gb_r <= 65'(rd_r); gk_r <= '0;
      end
      CMD_GCD_STEP: begin
        // Binary gcd: strip common twos, then subtract the odd values.
        if (ga_r == '0) begin
          ga_r <= gb_r; gb_r <= '0;
        end else if (both_even) begin
          ga_r <= ga_r >> 1; gb_r <= gb_r >> 1; gk_r <= gk_r + 7'd1;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else begin
          ga_r <= (ga_r < gb_r) ? ga_r : gb_r;
          gb_r <= gsub >> 1;
        end
      end
      CMD_DIV1_INIT, CMD_DIV2_INIT, CMD_DIVR_INIT: begin
        dcnt_r <= 7'd65;
        dq_r <= '0; dq2_r <= '0; drem_r <= '0; drem2_r <= '0;
        unique case (cmd)
          CMD_DIV1_INIT: begin
            dsel_r <= 2'd0; dn1_r <= 65'(n1m_r); dn2_r <= 65'(d1m_r);
          end
          CMD_DIV2_INIT: begin
            dsel_r <= 2'd1; dn1_r <= 65'(n2m_r); dn2_r <= 65'(d2m_r);
          end
          default: begin
            dsel_r <= 2'd2; dn1_r <= rnm_r; dn2_r <= 65'(rd_r);
          end
        endcase
      end
      CMD_DIV_STEP: begin
        dcnt_r <= dcnt_r - 7'd1;
        dn1_r <= dn1_r << 1;
        dn2_r <= dn2_r << 1;
        if (dtry1 >= g_r) begin
          drem_r <= dtry1 - g_r; dq_r <= {dq_r[63:0], 1'b1};
        end else begin
          drem_r <= dtry1; dq_r <= {dq_r[63:0], 1'b0};
        end
        if (dtry2 >= g_r) begin
          drem2_r <= dtry2 - g_r; dq2_r <= {dq2_r[63:0], 1'b1};
        end else begin
          drem2_r <= dtry2; dq2_r <= {dq2_r[63:0], 1'b0};
        end
        if (dcnt_r == 7'd1) begin
          unique case (dsel_r)
            2'd0: begin
              n1m_r <= (W+1)'({dq_r[63:0], dtry1 >= g_r});
              d1m_r <= (W+1)'({dq2_r[63:0], dtry2 >= g_r});
              n1s_r <= (n1m_r != '0) && (n1s_r != d1s_r);
            end
            2'd1: begin
              n2m_r <= (W+1)'({dq_r[63:0], dtry1 >= g_r});
              d2m_r <= (W+1)'({dq2_r[63:0], dtry2 >= g_r});
              n2s_r <= (n2m_r != '0) && (n2s_r != d2s_r);
            end
            default: begin
              rnm_r <= {dq_r[63:0], dtry1 >= g_r};
              rd_r  <= 64'({dq2_r[63:0], dtry2 >= g_r});
            end
          endcase
        end
      end
      CMD_MUL_A: p1_r <= mprod;
      CMD_MUL_B: rd_r <= mprod;
      CMD_MUL_C: p2_r <= mprod;
      CMD_COMBINE: begin
        if (opc_r == OP_MUL || opc_r == OP_DIV) begin
          rnm_r <= {1'b0, p1_r};
          rns_r <= n1s_r != n2s_r;
        end else if (n1s_r == (n2s_r ^ (opc_r == OP_SUB))) begin
          rnm_r <= {1'b0, p1_r} + {1'b0, p2_r};
          rns_r <= n1s_r;
        end else if (p1_r >= p2_r) begin
          rnm_r <= {1'b0, p1_r - p2_r};
          rns_r <= n1s_r;
        end else begin
          rnm_r <= {1'b0, p2_r - p1_r};
          rns_r <= n2s_r ^ (opc_r == OP_SUB);
        end
      end
      CMD_FINISH: begin
        out_num_r <= '0;
        out_den_r <= 63'd1;
        if (dp_st.zero_den) begin
          out_st_r <= ST_ZERO_DEN;
        end else if (dp_st.div_zero) begin
          out_st_r <= ST_DIV_ZERO;
        end else if (rnm_r == '0) begin
          out_st_r <= ST_OK;
        end else if (rnm_r[64:63] != 2'b00 || rd_r[63]) begin
          out_st_r <= ST_OVERFLOW;
        end else begin
          out_st_r <= ST_OK;
          out_num_r <= rns_r ? (~rnm_r[63:0] + 64'd1) : rnm_r[63:0];
          out_den_r <= rd_r[62:0];
        end
      end
      default: ;
    endcase
    // Latch the finished gcd with its common power of two restored.
    if (cmd == CMD_DIV1_INIT || cmd == CMD_DIV2_INIT || cmd == CMD_DIVR_INIT) begin
      g_r <= ga_r << gk_r;
    end
  end

  assign result_num = out_num_r;
  assign result_den = out_den_r;
  assign status     = out_st_r;

endmodule

[sv/rational_arithmetic_unit.sv]
// Top level of the rational arithmetic unit.
// Usage: present op and two fractions on the in_ channel with in_valid; the
// request is taken when in_valid and in_ready are both high. The block then
// normalizes each fraction with a binary gcd and a 65-step restoring
// division, forms the cross products on one shared 32x32 multiplier, and
// reduces the result the same way. One request is in flight at a time.
// Latency is data dependent and set by the serial gcd loop and divider.
// A zero denominator is reported straight from the check state, with no
// gcd or division, and a zero result skips the final reduction. The next
// request is taken the cycle after the result leaves. Results with status
// 0 carry the reduced fraction; any error gives 0/1 with the status code.
// The result waits on the out_ channel with out_valid high until out_ready;
// while the receiver stalls, no new request is taken.
// Reset (rst_n low, synchronous) returns the controller to idle.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_left_num,
  input  logic [31:0] in_left_den,
  input  logic [31:0] in_right_num,
  input  logic [31:0] in_right_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_result_num,
  output logic [62:0] out_result_den,
  output logic [1:0]  out_status
);
  import rau_pkg::*;

  cmd_t       cmd;
  dp_status_t dp_st;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .dp_st(dp_st), .cmd(cmd)
  );

  rau_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
    .clk(clk), .cmd(cmd), .op(in_op), .left_num(in_left_num),
    .left_den(in_left_den), .right_num(in_right_num), .right_den(in_right_den),
    .dp_st(dp_st), .result_num(out_result_num), .result_den(out_result_den),
    .status(out_status)
  );

endmodule

[tb/rau_checker.sv]
// Checker for the rational arithmetic unit: predicts each request and compares results.
module rau_checker #(
  parameter int unsigned OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [31:0] in_left_num,
  input  logic [31:0] in_left_den,
  input  logic [31:0] in_right_num,
  input  logic [31:0] in_right_den,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_result_num,
  input  logic [62:0] out_result_den,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending
);
  import rau_pkg::*;

  typedef struct {
    logic [63:0] num;
    logic [62:0] den;
    status_t     status;
  } fraction_t;

  fraction_t expected_fracs[$];
  localparam logic [63:0] MagMax = 64'h7FFF_FFFF_FFFF_FFFF;

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Sign and magnitude of an operand read at OPERAND_WIDTH bits.
  function automatic void split_operand(input logic [31:0] raw, output logic neg,
                                        output logic [63:0] mag);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (64'd1 << OPERAND_WIDTH) - 1;
    v = {32'd0, raw} & mask;
    neg = v[OPERAND_WIDTH-1];
    mag = neg ? ((~v + 1) & mask) : v;
    if (neg && mag == 0) mag = 64'd1 << (OPERAND_WIDTH - 1);
  endfunction

  function automatic void reduce_fraction(inout logic neg, inout logic [63:0] n,
                                          inout logic [63:0] d, input logic den_neg);
    logic [63:0] g;
    if (n == 0) begin
      neg = 0;
      d = 1;
    end else begin
      neg = neg ^ den_neg;
      g = gcd64(n, d);
      n = n / g;
      d = d / g;
    end
  endfunction

  function automatic fraction_t compute_fraction(logic [1:0] op, logic [31:0] ln,
                                                 logic [31:0] ld, logic [31:0] rn,
                                                 logic [31:0] rd);
    fraction_t f;
    logic n1s, d1s, n2s, d2s, ts1, ts2, rs;
    logic [63:0] n1, d1, n2, d2, t1, t2, rmag, rden, g;
    f.num = 0;
    f.den = 1;
    f.status = ST_OK;
    split_operand(ln, n1s, n1);
    split_operand(ld, d1s, d1);
    split_operand(rn, n2s, n2);
    split_operand(rd, d2s, d2);
    if (d1 == 0 || d2 == 0) begin
      f.status = ST_ZERO_DEN;
      return f;
    end
    reduce_fraction(n1s, n1, d1, d1s);
    reduce_fraction(n2s, n2, d2, d2s);
    case (op_t'(op)) inside
      OP_ADD, OP_SUB: begin
        ts1 = n1s;
        t1 = n1 * d2;
        ts2 = (op_t'(op) == OP_SUB) ? !n2s : n2s;
        t2 = n2 * d1;
        if (ts1 == ts2) begin
          rs = ts1;
          rmag = t1 + t2;
        end else if (t1 >= t2) begin
          rs = ts1;
          rmag = t1 - t2;
        end else begin
          rs = ts2;
          rmag = t2 - t1;
        end
        rden = d1 * d2;
      end
      OP_MUL: begin
        rs = n1s ^ n2s;
        rmag = n1 * n2;
        rden = d1 * d2;
      end
      default: begin
        if (n2 == 0) begin
          f.status = ST_DIV_ZERO;
          return f;
        end
        rs = n1s ^ n2s;
        rmag = n1 * d2;
        rden = d1 * n2;
      end
    endcase
    if (rmag == 0) return f;
    g = gcd64(rmag, rden);
    rmag = rmag / g;
    rden = rden / g;
    if (rmag > MagMax || rden > MagMax || rden == 0) begin
      f.status = ST_OVERFLOW;
    end else begin
      f.num = rs ? (~rmag + 1) : rmag;
      f.den = rden[62:0];
    end
    return f;
  endfunction

  always @(posedge clk) begin
    fraction_t exp_f;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_fracs.push_back(compute_fraction(in_op, in_left_num, in_left_den,
                                                  in_right_num, in_right_den));
      if (out_valid && out_ready) begin
        if (expected_fracs.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result %0d/%0d status %0d",
                                        $signed(out_result_num), out_result_den,
                                        out_status);
        end else begin
          exp_f = expected_fracs.pop_front();
          if (out_result_num !== exp_f.num || out_result_den !== exp_f.den ||
              out_status !== exp_f.status) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %0d/%0d st %0d, got %0d/%0d st %0d",
                       $signed(exp_f.num), exp_f.den, exp_f.status,
                       $signed(out_result_num), out_result_den, out_status);
          end
        end
      end
    end
    pending = expected_fracs.size();
  end
endmodule

[tb/tb_rational_arithmetic_unit.sv]
// Testbench top for the rational arithmetic unit: stimulus, reset and verdict.
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  logic clk, rst_n, in_valid, in_ready, out_valid, out_ready;
  logic [1:0] in_op, out_status;
  logic [31:0] in_left_num, in_left_den, in_right_num, in_right_den;
  logic [63:0] out_result_num;
  logic [62:0] out_result_den;
  int fail_count, pending;
  bit long_hold;

  rational_arithmetic_unit i_dut (.*);
  rau_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 0;
      3: return $urandom;
      4: return -$urandom_range(1, 20);
      default: return $urandom_range(1, 40) * (($urandom_range(0, 1)) ? 1 : -1);
    endcase
  endfunction

  task automatic send_request(logic [1:0] op, logic [31:0] ln, logic [31:0] ld,
                              logic [31:0] rn, logic [31:0] rd);
    in_valid <= 1;
    in_op <= op;
    in_left_num <= ln;
    in_left_den <= ld;
    in_right_num <= rn;
    in_right_den <= rd;
    do @(posedge clk); while (!in_ready);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 3))
        @(posedge clk);
    end
  endtask

  // Receiver: random stalls, plus one long hold-off while requests keep coming.
  initial begin
    bit held;
    held = 0;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      if (long_hold && !held) begin
        held = 1;
        out_ready <= 0;
        repeat (3000) @(posedge clk);
      end
      out_ready <= ($urandom_range(0, 3) != 0);
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(20, 400) : 1) @(posedge clk);
    end
  end

  initial begin
    logic [1:0] op;
    logic [31:0] ln, ld, rn, rd;
    rst_n = 0;
    in_valid = 0;
    in_op = 0;
    in_left_num = 0;
    in_left_den = 1;
    in_right_num = 0;
    in_right_den = 1;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int k = 0; k < 4; k++) begin
      send_request(2'(k), 3, 4, 5, -6);
      send_request(2'(k), 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1);
      send_request(2'(k), 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(2'(k), 0, -5, 7, 3);
      send_request(2'(k), 1, 0, 1, 1);
    end
    send_request(OP_DIV, 4, 9, 0, -2);
    send_request(OP_ADD, 2, 3, -2, 3);
    send_request(OP_MUL, -6, -4, 8, 32'hFFFF_FFFF);
    send_request(OP_SUB, 5, 7, 5, 7);
    send_request(OP_ADD, 32'hFFFF_FFFF, 32'hAAAA_5555, 32'h5555_AAAA, 32'hFFFF_FFFE);
    // Pause until every outstanding result has come back.
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    long_hold = 1;
    for (int k = 0; k < 1130; k++) begin
      op = 2'($urandom_range(0, 3));
      ln = pick_value();
      ld = pick_value();
      rn = pick_value();
      rd = pick_value();
      if (ld == 0 && $urandom_range(0, 3) != 0) ld = 1;
      if (rd == 0 && $urandom_range(0, 3) != 0) rd = -1;
      send_request(op, ln, ld, rn, rd);
    end
    in_valid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (700) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule
